>>> rtl/core/tcpd_pkg.sv
// ----------------------------------------------------------------------------
// tcpd_pkg
// Types, constants and key functions for the tolerant colour palette dedupe.
// ----------------------------------------------------------------------------
package tcpd_pkg;

    localparam int PaletteDepthDefault = 256;
    localparam logic [4:0] RangeReset = 5'd5;
    localparam int KeyW = 19;
    localparam logic [KeyW-1:0] KeyNone = {KeyW{1'b1}};

    localparam logic [1:0] RegRangeRed   = 2'd0;
    localparam logic [1:0] RegRangeGreen = 2'd1;
    localparam logic [1:0] RegRangeBlue  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] read_index;
    } t_in;

    typedef struct packed {
        logic        added;
        logic [7:0]  slot;
        logic [7:0]  slot_red;
        logic [7:0]  slot_green;
        logic [7:0]  slot_blue;
        logic [31:0] slot_hits;
        logic        slot_valid;
        logic        table_full;
        logic [8:0]  used_slots;
    } t_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [4:0] rr;
        logic [4:0] rg;
        logic [4:0] rb;
        logic       exact;
    } t_probe;

    // best (offset, sign) for one component, or none
    function automatic logic [6:0] comp_best(input logic [7:0] st, input logic [7:0] px,
                                             input logic [4:0] rng);
        logic [7:0] dp;
        logic [7:0] dn;
        logic       okp;
        logic       okn;
        logic [6:0] res;
        dp  = st - px;
        dn  = px - st;
        okp = {3'b000, rng} > dp;
        okn = {3'b000, rng} > dn;
        res = 7'b1000000;
        if (okp && (!okn || dp <= dn)) begin
            res = {1'b0, dp[4:0], 1'b0};
        end else if (okn) begin
            res = {1'b0, dn[4:0], 1'b1};
        end
        return res;
    endfunction

    function automatic logic [KeyW-1:0] probe_key(input logic [23:0] col, input t_probe p);
        logic [6:0] cr;
        logic [6:0] cg;
        logic [6:0] cb;
        logic [KeyW-1:0] k;
        cr = comp_best(col[23:16], p.r, p.rr);
        cg = comp_best(col[15:8], p.g, p.rg);
        cb = comp_best(col[7:0], p.b, p.rb);
        if (p.exact) begin
            k = (col == {p.r, p.g, p.b}) ? '0 : KeyNone;
        end else if (cr[6] || cg[6] || cb[6]) begin
            k = KeyNone;
        end else begin
            k = {1'b0, cr[5:1], cg[5:1], cb[5:1], cr[0], cg[0], cb[0]};
        end
        return k;
    endfunction

endpackage

>>> rtl/core/tolerant_color_palette_dedupe.sv
// ----------------------------------------------------------------------------
// tolerant_color_palette_dedupe
// Tolerant colour palette: cell chain finds the lowest-key matching entry,
// earliest on a tie. A request passes SCAN, UPDATE and REPLY; a pixel stays in
// SCAN while the key ripples one cell a cycle. Throughput: one transaction
// at a time; next start is taken in the cycle the result shows. The receiver
// cannot stall. Synchronous reset empties the palette and sets ranges to 5.
// ----------------------------------------------------------------------------
module tolerant_color_palette_dedupe
    import tcpd_pkg::*;
#(
    parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_req,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output logic        o_strobe,
    output t_out        o_res
);

    localparam int IdxW = $clog2(PALETTE_DEPTH);
    localparam int CntW = $clog2(PALETTE_DEPTH + 1);
    localparam int CycW = $clog2(PALETTE_DEPTH + 2);

    t_state r_state, n_state;
    t_in    r_req;
    logic [4:0] r_rr, r_rg, r_rb;
    logic [CntW-1:0] r_total;
    logic [CycW-1:0] r_cnt;
    logic [31:0] r_hits [PALETTE_DEPTH];
    logic [31:0] r_hit_rd;
    logic [IdxW-1:0] r_slot;
    logic r_found, r_add, r_full, r_clear, r_wr;
    logic r_hit_found;
    t_out r_res;
    t_out n_res;
    logic r_strobe;

    t_probe w_probe;
    logic [KeyW-1:0] w_key [PALETTE_DEPTH+1];
    logic [IdxW-1:0] w_idx [PALETTE_DEPTH+1];
    logic [23:0]     w_col [PALETTE_DEPTH];
    logic            w_val [PALETTE_DEPTH];
    logic            w_inrange;
    logic [IdxW-1:0] w_rd_slot;
    logic            w_miss;
    logic            w_new;

    assign w_probe = '{r: r_req.pixel_red, g: r_req.pixel_green, b: r_req.pixel_blue,
                       rr: r_rr, rg: r_rg, rb: r_rb,
                       exact: (r_rr == 5'd0) || (r_rg == 5'd0) || (r_rb == 5'd0)};
    assign w_key[0] = KeyNone;
    assign w_idx[0] = '0;

    for (genvar c = 0; c < PALETTE_DEPTH; c++) begin : g_cell
        tcpd_cell #(.IDX_W(IdxW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_mine     (r_total[IdxW-1:0] == IdxW'(c)),
            .i_clear    (r_clear),
            .i_wr       (r_wr),
            .i_wr_color ({r_req.pixel_red, r_req.pixel_green, r_req.pixel_blue}),
            .i_probe    (w_probe),
            .i_key      (w_key[c]),
            .i_idx      (w_idx[c]),
            .i_self     (IdxW'(c)),
            .o_key      (w_key[c+1]),
            .o_idx      (w_idx[c+1]),
            .o_color    (w_col[c]),
            .o_valid    (w_val[c])
        );
    end

    assign busy = r_state != ST_IDLE;
    assign o_strobe = r_strobe;
    assign o_res = r_res;
    assign w_inrange = {24'd0, r_req.read_index} < 32'(PALETTE_DEPTH);
    assign w_rd_slot = r_req.req_type ? IdxW'(r_req.read_index) : r_slot;
    assign w_miss = w_key[PALETTE_DEPTH] == KeyNone;
    assign w_new = !r_req.req_type && w_miss && (r_total != CntW'(PALETTE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_SCAN;
            ST_SCAN:   if (r_req.req_type || r_cnt == CycW'(PALETTE_DEPTH + 1))
                           n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_REPLY;
            ST_REPLY:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rr     <= RangeReset;
            r_rg     <= RangeReset;
            r_rb     <= RangeReset;
            r_total  <= '0;
            r_strobe <= 1'b0;
            r_clear  <= 1'b1;
            r_wr     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= r_state == ST_REPLY;
            r_clear  <= (r_state == ST_IDLE) && start;
            r_wr     <= (r_state == ST_SCAN) && (n_state == ST_UPDATE) && w_new;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegRangeRed:   r_rr <= i_cfg_data;
                    RegRangeGreen: r_rg <= i_cfg_data;
                    RegRangeBlue:  r_rb <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (start) begin
                        r_req <= i_req;
                    end
                end
                ST_SCAN: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_found <= !w_miss;
                    r_slot  <= w_miss ? r_total[IdxW-1:0] : w_idx[PALETTE_DEPTH];
                    r_add   <= w_new;
                    r_full  <= !r_req.req_type && w_miss
                               && (r_total == CntW'(PALETTE_DEPTH));
                end
                ST_UPDATE: begin
                    if (r_add) r_total <= r_total + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // hit memory: read in UPDATE, write in REPLY
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_hit_rd <= r_hits[w_rd_slot];
            r_hit_found <= r_found && !w_probe.exact && !r_req.req_type;
        end
        if (r_state == ST_REPLY && !r_req.req_type) begin
            if (r_add) begin
                r_hits[r_slot] <= '0;
            end else if (r_hit_found && r_hit_rd != '1) begin
                r_hits[r_slot] <= r_hit_rd + 1'b1;
            end
        end
    end

    always_comb begin
        n_res = '0;
        n_res.used_slots = 9'(r_total);
        if (r_req.req_type) begin
            n_res.slot = r_req.read_index;
            if (w_inrange && w_val[w_rd_slot]) begin
                n_res.slot_valid = 1'b1;
                {n_res.slot_red, n_res.slot_green, n_res.slot_blue} = w_col[w_rd_slot];
                n_res.slot_hits = r_hit_rd;
            end
        end else if (r_full) begin
            n_res.table_full = 1'b1;
        end else begin
            n_res.added = r_add;
            n_res.slot = 8'(r_slot);
            n_res.slot_valid = 1'b1;
            {n_res.slot_red, n_res.slot_green, n_res.slot_blue} = w_col[r_slot];
            n_res.slot_hits = r_add ? 32'd0 :
                              (r_hit_found && r_hit_rd != '1) ? r_hit_rd + 1'b1
                                                              : r_hit_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_REPLY) begin
            r_res <= n_res;
        end
    end

endmodule

>>> rtl/core/tcpd_cell.sv
// ----------------------------------------------------------------------------
// tcpd_cell
// One palette entry: holds colour, evaluates probe key, passes best onward.
// ----------------------------------------------------------------------------
module tcpd_cell
    import tcpd_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mine,
    input  logic              i_clear,
    input  logic              i_wr,
    input  logic [23:0]       i_wr_color,
    input  t_probe            i_probe,
    input  logic [KeyW-1:0]   i_key,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [IDX_W-1:0]  i_self,
    output logic [KeyW-1:0]   o_key,
    output logic [IDX_W-1:0]  o_idx,
    output logic [23:0]       o_color,
    output logic              o_valid
);

    logic [23:0]     r_color;
    logic            r_valid;
    logic [KeyW-1:0] w_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_mine && i_wr) begin
            r_valid <= 1'b1;
        end
        if (i_mine && i_wr) begin
            r_color <= i_wr_color;
        end
    end

    assign w_key = r_valid ? probe_key(r_color, i_probe) : KeyNone;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            o_key <= KeyNone;
            o_idx <= '0;
        end else if (w_key < i_key) begin
            o_key <= w_key;
            o_idx <= i_self;
        end else begin
            o_key <= i_key;
            o_idx <= i_idx;
        end
    end

    assign o_color = r_color;
    assign o_valid = r_valid;

endmodule
